@@ design/mfc_pkg.sv @@
// Shared types, codes and constants of the magnetometer filter and calibration block.
`timescale 1ns / 1ps
package mfc_pkg;

	localparam int WINDOW_LENGTH_DEF   = 10;
	localparam int SCALE_FRAC_BITS_DEF = 12;
	localparam int AXES                = 3;
	localparam int SAMPLE_W            = 16;
	// Width of an axis range or of an average less an offset.
	localparam int DEN_W               = SAMPLE_W + 1;
	localparam int MAG_W               = 21;
	localparam int CFG_IDX_W           = 3;

	localparam logic signed [SAMPLE_W-1:0] PRESET_EXTREME = 16'sd32400;

	typedef logic [AXES-1:0][SAMPLE_W-1:0] row_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_START  = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_X = 3'd0,
		REG_OFFSET_Y = 3'd1,
		REG_OFFSET_Z = 3'd2,
		REG_SCALE_X  = 3'd3,
		REG_SCALE_Y  = 3'd4,
		REG_SCALE_Z  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_SUM,
		S_DIVS,
		S_DIVW,
		S_MUL,
		S_SAT,
		S_FCHK,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic start;
		logic short_mode;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic neg;
	} div_rsp_t;

endpackage

@@ design/mfc_window.sv @@
// Sample window memory, one row of three axes per slot, with per-row valid bits.
`timescale 1ns / 1ps
module mfc_window import mfc_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic                             wr_en,
	input  logic [$clog2(WINDOW_LENGTH)-1:0] slot,
	input  row_t                             wr_row,
	output row_t                             rd_row
);

	row_t                     mem [WINDOW_LENGTH];
	logic [WINDOW_LENGTH-1:0] vld_q;
	row_t                     rd_data_q;
	logic                     rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[slot] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[slot];
			end
		end
	end

	// A row never written holds zero samples.
	assign rd_row = rd_vld_q ? rd_data_q : '0;

endmodule

@@ design/mfc_divider.sv @@
// Shared signed divider, two quotient bits a cycle, truncating toward zero.
`timescale 1ns / 1ps
module mfc_divider import mfc_pkg::*; #(
	parameter int NUM_W = DEN_W + SCALE_FRAC_BITS_DEF,
	parameter int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH_DEF)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  div_req_t                          req,
	input  logic signed [NUM_W-1:0]           num,
	input  logic signed [DEN_W-1:0]           den,
	output div_rsp_t                          rsp,
	output logic [2*((NUM_W+1)/2)-1:0]        quo
);

	localparam int LONG_STEPS  = (NUM_W + 1) / 2;
	localparam int SHORT_STEPS = (SUM_W + 1) / 2;
	localparam int QW          = 2 * LONG_STEPS;
	localparam int SHIFT       = 2 * (LONG_STEPS - SHORT_STEPS);
	localparam int CNT_W       = $clog2(LONG_STEPS + 1);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [QW-1:0]    dvd_q;
	logic [QW-1:0]    quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dsr_q;

	logic [NUM_W-1:0] num_mag;
	logic [QW-1:0]    mag_ext;
	logic [DEN_W-1:0] den_mag;
	logic [DEN_W:0]   r1;
	logic [DEN_W:0]   r2;
	logic [DEN_W:0]   t1;
	logic [DEN_W:0]   t2;
	logic             q1;
	logic             q2;
	logic [DEN_W-1:0] rem1;
	logic [DEN_W-1:0] rem2;

	always_comb begin
		num_mag = num[NUM_W-1] ? (NUM_W'(0) - $unsigned(num)) : $unsigned(num);
		den_mag = den[DEN_W-1] ? (DEN_W'(0) - $unsigned(den)) : $unsigned(den);
		mag_ext = QW'(num_mag);

		r1   = {rem_q, dvd_q[QW-1]};
		t1   = r1 - {1'b0, dsr_q};
		q1   = (r1 >= {1'b0, dsr_q});
		rem1 = q1 ? t1[DEN_W-1:0] : r1[DEN_W-1:0];

		r2   = {rem1, dvd_q[QW-2]};
		t2   = r2 - {1'b0, dsr_q};
		q2   = (r2 >= {1'b0, dsr_q});
		rem2 = q2 ? t2[DEN_W-1:0] : r2[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.short_mode ? CNT_W'(SHORT_STEPS) : CNT_W'(LONG_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// A short dividend is moved up so that fewer steps cover it.
			dvd_q <= req.short_mode ? (mag_ext << SHIFT) : mag_ext;
			rem_q <= '0;
			quo_q <= '0;
			dsr_q <= den_mag;
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 2;
			rem_q <= rem2;
			quo_q <= {quo_q[QW-3:0], q1, q2};
		end
	end

	assign rsp.done = done_q;
	assign rsp.neg  = neg_q;
	assign quo      = quo_q;

endmodule

@@ design/mag_filter_calibrator.sv @@
// Top level of the three-axis magnetometer filter and calibration block.
// A sample word and a successful finish use the shared divider; a failed finish and other
// commands do not. One word is in work at a time, the next is taken once the result sits in
// the output register. Reset clears window, sums, extremes and tracking, sets offsets to
// zero and gains to one.
`timescale 1ns / 1ps
module mag_filter_calibrator import mfc_pkg::*; #(
	parameter int WINDOW_LENGTH   = WINDOW_LENGTH_DEF,
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic signed [SAMPLE_W-1:0]  raw_x,
	input  logic signed [SAMPLE_W-1:0]  raw_y,
	input  logic signed [SAMPLE_W-1:0]  raw_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [MAG_W-1:0]     mag_x,
	output logic signed [MAG_W-1:0]     mag_y,
	output logic signed [MAG_W-1:0]     mag_z,
	output logic signed [SAMPLE_W-1:0]  new_offset_x,
	output logic signed [SAMPLE_W-1:0]  new_offset_y,
	output logic signed [SAMPLE_W-1:0]  new_offset_z,
	output logic [SAMPLE_W-1:0]         new_scale_y,
	output logic [SAMPLE_W-1:0]         new_scale_z,
	output logic                        calib_done,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [SAMPLE_W-1:0]         cfg_data
);

	localparam int SLOT_W = $clog2(WINDOW_LENGTH);
	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LENGTH);
	localparam int NUM_W  = (SUM_W > DEN_W + SCALE_FRAC_BITS) ? SUM_W : DEN_W + SCALE_FRAC_BITS;
	localparam int QW     = 2 * ((NUM_W + 1) / 2);
	localparam int PROD_W = 2 * DEN_W - 1;

	localparam logic [SAMPLE_W-1:0]      ONE       = SAMPLE_W'(1 << SCALE_FRAC_BITS);
	localparam logic [SLOT_W-1:0]        LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);
	localparam logic signed [DEN_W-1:0]  WIN_DEN   = DEN_W'(WINDOW_LENGTH);
	localparam logic signed [PROD_W-1:0] RND       = PROD_W'((1 << SCALE_FRAC_BITS) - 1);
	localparam logic signed [PROD_W-1:0] MAG_HI    = PROD_W'((1 << (MAG_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0] MAG_LO    = -MAG_HI - PROD_W'(1);

	state_t state_q;
	state_t state_d;

	logic [1:0]                 axis_q;
	logic [1:0]                 cmd_q;
	row_t                       s_q;
	row_t                       old_row;
	logic signed [SUM_W-1:0]    sum_q    [AXES];
	logic signed [SAMPLE_W-1:0] min_q    [AXES];
	logic signed [SAMPLE_W-1:0] max_q    [AXES];
	logic signed [SAMPLE_W-1:0] offset_q [AXES];
	logic [SAMPLE_W-1:0]        scale_q  [AXES];
	logic                       tracking_q;
	logic [SLOT_W-1:0]          slot_q;
	logic signed [SAMPLE_W-1:0] avg_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [DEN_W-1:0]    range_q  [AXES];

	logic [MAG_W-1:0]    rmag_q [AXES];
	logic [SAMPLE_W-1:0] roff_q [AXES];
	logic [SAMPLE_W-1:0] rsy_q;
	logic [SAMPLE_W-1:0] rsz_q;
	logic                rdone_q;

	logic [MAG_W-1:0]    omag_q [AXES];
	logic [SAMPLE_W-1:0] ooff_q [AXES];
	logic [SAMPLE_W-1:0] osy_q;
	logic [SAMPLE_W-1:0] osz_q;
	logic                odone_q;
	logic                out_valid_q;

	logic     accept;
	logic     rd_en;
	logic     wr_en;
	logic     load_out;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [QW-1:0]           quo;
	logic signed [NUM_W-1:0] div_num;
	logic signed [DEN_W-1:0] div_den;

	logic signed [SUM_W-1:0]    sum_n;
	logic signed [SAMPLE_W-1:0] avg_n;
	logic signed [PROD_W:0]     mul_full;
	logic [MAG_W-1:0]           mag_sat;
	logic [SAMPLE_W-1:0]        ratio_sat;
	logic                       any_eq;
	logic signed [DEN_W-1:0]    range_n [AXES];
	logic [SAMPLE_W-1:0]        mid_n   [AXES];

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	mfc_window #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.wr_en  (wr_en),
		.slot   (slot_q),
		.wr_row (s_q),
		.rd_row (old_row)
	);

	mfc_divider #(
		.NUM_W(NUM_W),
		.SUM_W(SUM_W)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.rsp    (div_rsp),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		load_out = 1'b0;
		div_req  = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd)
						CMD_SAMPLE: begin
							rd_en   = 1'b1;
							state_d = S_RD;
						end
						CMD_FINISH: state_d = S_FCHK;
						default:    state_d = S_LOAD;
					endcase
				end
			end
			S_RD: begin
				wr_en   = 1'b1;
				state_d = S_SUM;
			end
			S_SUM:  state_d = S_DIVS;
			S_DIVS: begin
				div_req.start      = 1'b1;
				div_req.short_mode = (cmd_q == CMD_SAMPLE);
				state_d            = S_DIVW;
			end
			S_DIVW: begin
				if (div_rsp.done) begin
					if (cmd_q == CMD_SAMPLE) begin
						state_d = S_MUL;
					end else if (axis_q == 2'd1) begin
						state_d = S_DIVS;
					end else begin
						state_d = S_LOAD;
					end
				end
			end
			S_MUL:  state_d = S_SAT;
			S_SAT:  state_d = (axis_q == 2'd2) ? S_LOAD : S_SUM;
			S_FCHK: state_d = any_eq ? S_LOAD : S_DIVS;
			S_LOAD: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		logic signed [NUM_W-1:0]  rx_ext;
		logic signed [DEN_W-1:0]  diff;
		logic signed [PROD_W-1:0] adj;
		logic signed [PROD_W-1:0] shifted;
		logic [16:0]              qlo;
		logic [16:0]              qneg;
		logic signed [DEN_W-1:0]  msum;
		logic signed [DEN_W-1:0]  mtmp;
		logic signed [DEN_W-1:0]  half;

		rx_ext  = NUM_W'(range_q[0]);
		div_num = (cmd_q == CMD_SAMPLE) ? NUM_W'(sum_q[axis_q])
		                                : (rx_ext <<< SCALE_FRAC_BITS);
		div_den = (cmd_q == CMD_SAMPLE) ? WIN_DEN : range_q[axis_q];

		sum_n = sum_q[axis_q] + SUM_W'($signed(s_q[axis_q]))
		        - SUM_W'($signed(old_row[axis_q]));

		qlo   = quo[16:0];
		qneg  = 17'd0 - qlo;
		avg_n = div_rsp.neg ? qneg[SAMPLE_W-1:0] : qlo[SAMPLE_W-1:0];

		diff     = DEN_W'(avg_q) - DEN_W'(offset_q[axis_q]);
		mul_full = diff * $signed({1'b0, scale_q[axis_q]});

		// Negative products are biased so that the shift truncates toward zero.
		adj     = prod_q + (prod_q[PROD_W-1] ? RND : PROD_W'(0));
		shifted = adj >>> SCALE_FRAC_BITS;
		if (shifted > MAG_HI) begin
			mag_sat = MAG_HI[MAG_W-1:0];
		end else if (shifted < MAG_LO) begin
			mag_sat = MAG_LO[MAG_W-1:0];
		end else begin
			mag_sat = shifted[MAG_W-1:0];
		end

		if (div_rsp.neg) begin
			ratio_sat = '0;
		end else if (|quo[QW-1:SAMPLE_W]) begin
			ratio_sat = '1;
		end else begin
			ratio_sat = quo[SAMPLE_W-1:0];
		end

		any_eq = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			if (max_q[a] == min_q[a]) begin
				any_eq = 1'b1;
			end
			range_n[a] = DEN_W'(max_q[a]) - DEN_W'(min_q[a]);
			msum       = DEN_W'(max_q[a]) + DEN_W'(min_q[a]);
			mtmp       = msum + $signed({{(DEN_W-1){1'b0}}, msum[DEN_W-1]});
			half       = mtmp >>> 1;
			mid_n[a]   = half[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q      <= '0;
			tracking_q  <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a]    <= '0;
				min_q[a]    <= '0;
				max_q[a]    <= '0;
				offset_q[a] <= '0;
				scale_q[a]  <= ONE;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_OFFSET_X: offset_q[0] <= cfg_data;
					REG_OFFSET_Y: offset_q[1] <= cfg_data;
					REG_OFFSET_Z: offset_q[2] <= cfg_data;
					REG_SCALE_X:  scale_q[0]  <= cfg_data;
					REG_SCALE_Y:  scale_q[1]  <= cfg_data;
					REG_SCALE_Z:  scale_q[2]  <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					axis_q <= '0;
					if (accept && (cmd == CMD_START)) begin
						tracking_q <= 1'b1;
						for (int a = 0; a < AXES; a++) begin
							max_q[a]    <= -PRESET_EXTREME;
							min_q[a]    <= PRESET_EXTREME;
							offset_q[a] <= '0;
							scale_q[a]  <= ONE;
						end
					end
				end
				S_RD: begin
					slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
				end
				S_SUM: sum_q[axis_q] <= sum_n;
				S_MUL: begin
					if (tracking_q) begin
						if (avg_q < min_q[axis_q]) begin
							min_q[axis_q] <= avg_q;
						end
						if (avg_q > max_q[axis_q]) begin
							max_q[axis_q] <= avg_q;
						end
					end
				end
				S_SAT: begin
					if (axis_q != 2'd2) begin
						axis_q <= axis_q + 2'd1;
					end
				end
				S_FCHK: axis_q <= 2'd1;
				S_DIVW: begin
					if (div_rsp.done && (cmd_q != CMD_SAMPLE)) begin
						if (axis_q == 2'd1) begin
							axis_q <= 2'd2;
						end else begin
							tracking_q <= 1'b0;
							scale_q[0] <= ONE;
							scale_q[1] <= rsy_q;
							scale_q[2] <= ratio_sat;
						end
					end
				end
				default: ;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			s_q[0]   <= raw_y;
			s_q[1]   <= SAMPLE_W'(0) - raw_x;
			s_q[2]   <= raw_z;
			rsy_q    <= '0;
			rsz_q    <= '0;
			rdone_q  <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				rmag_q[a] <= '0;
				roff_q[a] <= '0;
			end
		end
		case (state_q)
			S_DIVW: begin
				if (div_rsp.done) begin
					if (cmd_q == CMD_SAMPLE) begin
						avg_q <= avg_n;
					end else if (axis_q == 2'd1) begin
						rsy_q <= ratio_sat;
					end else begin
						rsz_q   <= ratio_sat;
						rdone_q <= 1'b1;
					end
				end
			end
			S_MUL: prod_q <= mul_full[PROD_W-1:0];
			S_SAT: rmag_q[axis_q] <= mag_sat;
			S_FCHK: begin
				for (int a = 0; a < AXES; a++) begin
					range_q[a] <= range_n[a];
					if (!any_eq) begin
						roff_q[a] <= mid_n[a];
					end
				end
			end
			default: ;
		endcase
		if (load_out) begin
			osy_q   <= rsy_q;
			osz_q   <= rsz_q;
			odone_q <= rdone_q;
			for (int a = 0; a < AXES; a++) begin
				omag_q[a] <= rmag_q[a];
				ooff_q[a] <= roff_q[a];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign mag_x        = omag_q[0];
	assign mag_y        = omag_q[1];
	assign mag_z        = omag_q[2];
	assign new_offset_x = ooff_q[0];
	assign new_offset_y = ooff_q[1];
	assign new_offset_z = ooff_q[2];
	assign new_scale_y  = osy_q;
	assign new_scale_z  = osz_q;
	assign calib_done   = odone_q;

`ifndef SYNTHESIS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT)
		else $error("window slot beyond the window length");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q != 2'd3)
		else $error("axis counter out of range");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIVW))
		else $error("divider finished while the sequencer was not waiting");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> $past(rd_en))
		else $error("window row written without the old row read first");

	a_finish_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVW && div_rsp.done && cmd_q == CMD_FINISH && axis_q == 2'd2)
		|=> (!tracking_q && scale_q[0] == ONE && rdone_q))
		else $error("successful finish did not stop tracking or reset the first gain");
`endif

endmodule
